// ----- rtl/rptd_pkg.sv -----
// Package: shared constants, types and helper functions of the threat detector.
`timescale 1ns / 1ps
package rptd_pkg;

   localparam int RULE_SLOTS_DEF     = 64;
   localparam int PATTERN_BYTES_DEF  = 62;
   localparam int THREAT_SLOTS_DEF   = 128;
   localparam int RESPONSE_SLOTS_DEF = 64;

   // widest pattern length value (up to 62 bytes)
   localparam int LEN_W = 6;
   localparam int HIT_W = 16;

   localparam logic [HIT_W-1:0] HIT_MAX  = '1;
   localparam logic [6:0]       CONF_CAP = 7'd100;
   localparam logic [6:0]       CONF_STEP = 7'd20;

   localparam logic MODE_PATTERN = 1'b0;
   localparam logic MODE_EVENT   = 1'b1;
   localparam logic KIND_RULE    = 1'b0;
   localparam logic KIND_EVENT   = 1'b1;

   localparam logic [2:0] CLASS_MALWARE = 3'd0;
   localparam logic [2:0] CLASS_DOS     = 3'd2;
   localparam logic [2:0] CLASS_PRIV    = 3'd4;
   localparam logic [2:0] CLASS_ANOMALY = 3'd5;

   localparam logic [1:0] SEVERITY_MEDIUM   = 2'd1;
   localparam logic [1:0] SEVERITY_HIGH     = 2'd2;
   localparam logic [1:0] SEVERITY_CRITICAL = 2'd3;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic             wr_en;
      logic [LEN_W-1:0] wr_pos;
      logic [7:0]       wr_byte;
      logic             add_en;
      logic [LEN_W-1:0] add_len;
      logic [2:0]       add_act;
      logic [7:0]       add_thr;
      logic             feed_en;
      logic [7:0]       feed_byte;
      logic             clear_en;
   } ctrl_type;

   // scan report of a cell, all zero unless the cell holds the token
   typedef struct packed {
      logic             stop;
      logic             trig;
      logic [HIT_W-1:0] hit;
      logic [2:0]       act;
   } report_type;

   function automatic logic [2:0] map_class(input logic [2:0] src);
      return (src <= CLASS_PRIV) ? src : CLASS_ANOMALY;
   endfunction

   function automatic logic [1:0] map_severity(input logic [2:0] src);
      if (src > CLASS_PRIV) return SEVERITY_MEDIUM;
      if (src == CLASS_MALWARE || src == CLASS_DOS) return SEVERITY_HIGH;
      return SEVERITY_CRITICAL;
   endfunction

   function automatic logic [6:0] confidence(input logic [HIT_W-1:0] hit);
      if (hit >= HIT_W'(5)) return CONF_CAP;
      return 7'(hit[2:0]) * CONF_STEP;
   endfunction

endpackage

// ----- rtl/rptd_cell.sv -----
// One rule cell: pattern bytes, shift-and match state, hit count and scan token stage.
`timescale 1ns / 1ps
module rptd_cell #(
   parameter int PATTERN_BYTES = rptd_pkg::PATTERN_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rptd_pkg::ctrl_type   ctrl,
   input  logic                 sel,
   input  logic                 token_in,
   output logic                 token_out,
   output rptd_pkg::report_type report
);

   logic [7:0]                     pat_ff [PATTERN_BYTES];
   logic [rptd_pkg::LEN_W-1:0]     len_ff;
   logic [2:0]                     act_ff;
   logic [7:0]                     thr_ff;
   logic [rptd_pkg::HIT_W-1:0]     hit_ff, hit_in;
   logic [PATTERN_BYTES-1:0]       part_ff, part_in;
   logic                           seen_ff, seen_in;
   logic                           occ_ff;
   logic                           token_ff;

   logic [PATTERN_BYTES-1:0]       eq_vec, len_mask, nxt;
   logic                           tail_hit;
   logic                           matched, trig;
   logic [rptd_pkg::HIT_W-1:0]     hit_inc;

   // compare the event byte against every stored position
   always_comb begin
      tail_hit = 1'b0;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         eq_vec[k]   = (pat_ff[k] == ctrl.feed_byte);
         len_mask[k] = (rptd_pkg::LEN_W'(k) < len_ff);
      end
      nxt = {part_ff[PATTERN_BYTES-2:0], 1'b1} & eq_vec & len_mask;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         if (rptd_pkg::LEN_W'(k + 1) == len_ff && nxt[k]) tail_hit = 1'b1;
      end
   end

   // scan step while holding the token
   always_comb begin
      matched = seen_ff || (len_ff == '0);
      hit_inc = (hit_ff == rptd_pkg::HIT_MAX) ? hit_ff : hit_ff + 1'b1;
      trig    = matched && (hit_inc >= rptd_pkg::HIT_W'(thr_ff));
      token_out = token_ff && occ_ff && !trig;
      report.stop = token_ff && (!occ_ff || trig);
      report.trig = token_ff && occ_ff && trig;
      report.hit  = (token_ff && occ_ff) ? hit_inc : '0;
      report.act  = (token_ff && occ_ff) ? act_ff : '0;
   end

   // next match state and hit count
   always_comb begin
      part_in = part_ff;
      seen_in = seen_ff;
      hit_in  = hit_ff;
      if (ctrl.add_en && sel) begin
         part_in = '0;
         seen_in = 1'b0;
         hit_in  = '0;
      end else if (ctrl.clear_en) begin
         part_in = '0;
         seen_in = 1'b0;
      end else if (ctrl.feed_en && occ_ff && len_ff != '0) begin
         part_in = nxt;
         seen_in = seen_ff | tail_hit;
      end
      if (token_ff && occ_ff && matched) hit_in = hit_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff  <= '0;
         seen_ff  <= 1'b0;
         occ_ff   <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         part_ff  <= part_in;
         seen_ff  <= seen_in;
         token_ff <= token_in;
         if (ctrl.add_en && sel) occ_ff <= 1'b1;
      end
   end

   // payload: hit count, pattern bytes and rule settings
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         if (ctrl.wr_en && sel && ctrl.wr_pos == rptd_pkg::LEN_W'(k)) pat_ff[k] <= ctrl.wr_byte;
      end
      if (ctrl.add_en && sel) begin
         len_ff <= ctrl.add_len;
         act_ff <= ctrl.add_act;
         thr_ff <= ctrl.add_thr;
      end
   end

endmodule

// ----- rtl/rule_pattern_threat_detector.sv -----
// Top level: rule loading, event byte broadcast, token scan over the cell row and result register.
// Timing: a rule-add result appears in the cycle after its final item. An event result
//   follows the end-of-event scan, in which the scan token moves one rule cell per cycle
//   until a cell triggers, an empty cell is reached or the row ends.
// Throughput: one item per cycle, except busy stays high during the end-of-event scan.
// The receiver cannot stall: each result beat is on the rsp_ ports for one cycle.
// Reset: synchronous; clears rule count, totals, match state and valid bits of the cells.
`timescale 1ns / 1ps
module rule_pattern_threat_detector #(
   parameter int RULE_SLOTS     = rptd_pkg::RULE_SLOTS_DEF,
   parameter int PATTERN_BYTES  = rptd_pkg::PATTERN_BYTES_DEF,
   parameter int THREAT_SLOTS   = rptd_pkg::THREAT_SLOTS_DEF,
   parameter int RESPONSE_SLOTS = rptd_pkg::RESPONSE_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  logic [7:0] req_char_byte,
   input  logic       req_has_char,
   input  logic       req_final_char,
   input  logic [2:0] req_rule_action,
   input  logic [7:0] req_rule_threshold,
   input  logic [2:0] req_source_class,
   output logic       rsp_valid,
   output logic       rsp_result_kind,
   output logic       rsp_accepted,
   output logic [6:0] rsp_rule_number,
   output logic [7:0] rsp_threat_number,
   output logic [2:0] rsp_threat_class,
   output logic [1:0] rsp_severity_level,
   output logic [6:0] rsp_confidence_pct,
   output logic       rsp_response_logged,
   output logic [6:0] rsp_response_number,
   output logic [2:0] rsp_action_taken
);

   localparam int RT_W = $clog2(RULE_SLOTS + 1);
   localparam int TT_W = $clog2(THREAT_SLOTS + 1);
   localparam int RS_W = $clog2(RESPONSE_SLOTS + 1);
   localparam int LP_W = rptd_pkg::LEN_W;

   logic [RT_W-1:0] rule_total_ff, rule_total_in;
   logic [LP_W-1:0] load_pos_ff, load_pos_in;
   logic [TT_W-1:0] threat_total_ff, threat_total_in;
   logic [RS_W-1:0] resp_total_ff, resp_total_in;
   logic            scan_ff, scan_in;
   logic [RT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [2:0]      src_ff, src_in;

   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic       acc_ff, acc_in;
   logic [6:0] rule_no_ff, rule_no_in;
   logic [7:0] threat_no_ff, threat_no_in;
   logic [2:0] class_ff, class_in;
   logic [1:0] sev_ff, sev_in;
   logic [6:0] conf_ff, conf_in;
   logic       logged_ff, logged_in;
   logic [6:0] resp_no_ff, resp_no_in;
   logic [2:0] act_ff, act_in;

   rptd_pkg::ctrl_type   ctrl;
   rptd_pkg::report_type reports [RULE_SLOTS];
   rptd_pkg::report_type rpt;
   logic [RULE_SLOTS-1:0] sel_vec;
   logic [RULE_SLOTS:0]   tok_chain;
   logic [RULE_SLOTS-1:0] tok_vec;

   logic accept, room, take_byte, scan_start, scan_done;

   assign accept     = start && !busy;
   assign room       = rule_total_ff < RT_W'(RULE_SLOTS);
   assign take_byte  = req_has_char && (load_pos_ff < LP_W'(PATTERN_BYTES));
   assign scan_start = accept && req_mode == rptd_pkg::MODE_EVENT && req_final_char;
   assign busy       = scan_ff;

   // broadcast to the cell row
   always_comb begin
      ctrl.wr_en     = accept && req_mode == rptd_pkg::MODE_PATTERN && take_byte && room;
      ctrl.wr_pos    = load_pos_ff;
      ctrl.wr_byte   = req_char_byte;
      ctrl.add_en    = accept && req_mode == rptd_pkg::MODE_PATTERN && req_final_char && room;
      ctrl.add_len   = load_pos_ff + LP_W'(take_byte);
      ctrl.add_act   = req_rule_action;
      ctrl.add_thr   = req_rule_threshold;
      ctrl.feed_en   = accept && req_mode == rptd_pkg::MODE_EVENT && req_has_char;
      ctrl.feed_byte = req_char_byte;
      ctrl.clear_en  = scan_done;
   end

   assign tok_chain[0] = scan_start;

   genvar gi;
   generate
      for (gi = 0; gi < RULE_SLOTS; gi++) begin : g_cell
         assign sel_vec[gi] = (rule_total_ff == RT_W'(gi));
         rptd_cell #(
            .PATTERN_BYTES(PATTERN_BYTES)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .sel      (sel_vec[gi]),
            .token_in (tok_chain[gi]),
            .token_out(tok_chain[gi+1]),
            .report   (reports[gi])
         );
         assign tok_vec[gi] = reports[gi].stop || tok_chain[gi+1];
      end
   endgenerate

   // merge the reports; only the token holder drives nonzero bits
   always_comb begin
      rpt = '0;
      for (int i = 0; i < RULE_SLOTS; i++) rpt = rpt | reports[i];
   end

   assign scan_done = scan_ff && (rpt.stop || tok_chain[RULE_SLOTS]);

   // control and result next state
   always_comb begin
      rule_total_in   = rule_total_ff;
      load_pos_in     = load_pos_ff;
      threat_total_in = threat_total_ff;
      resp_total_in   = resp_total_ff;
      scan_in         = scan_ff;
      scan_idx_in     = scan_idx_ff;
      src_in          = src_ff;
      valid_in        = 1'b0;
      kind_in         = rptd_pkg::KIND_RULE;
      acc_in          = 1'b0;
      rule_no_in      = '0;
      threat_no_in    = '0;
      class_in        = '0;
      sev_in          = '0;
      conf_in         = '0;
      logged_in       = 1'b0;
      resp_no_in      = '0;
      act_in          = '0;
      if (accept && req_mode == rptd_pkg::MODE_PATTERN) begin
         if (take_byte) load_pos_in = load_pos_ff + 1'b1;
         if (req_final_char) begin
            load_pos_in = '0;
            valid_in    = 1'b1;
            if (room) begin
               rule_total_in = rule_total_ff + 1'b1;
               acc_in        = 1'b1;
               rule_no_in    = 7'(rule_total_ff + 1'b1);
            end
         end
      end
      if (scan_start) begin
         scan_in     = 1'b1;
         scan_idx_in = '0;
         src_in      = req_source_class;
      end
      if (scan_ff) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (scan_done) begin
         scan_in  = 1'b0;
         valid_in = 1'b1;
         kind_in  = rptd_pkg::KIND_EVENT;
         if (rpt.trig) begin
            rule_no_in = 7'(scan_idx_ff + 1'b1);
            class_in   = rptd_pkg::map_class(src_ff);
            sev_in     = rptd_pkg::map_severity(src_ff);
            conf_in    = rptd_pkg::confidence(rpt.hit);
            act_in     = rpt.act;
            if (threat_total_ff < TT_W'(THREAT_SLOTS)) begin
               threat_total_in = threat_total_ff + 1'b1;
               acc_in          = 1'b1;
               threat_no_in    = 8'(threat_total_ff + 1'b1);
               if (resp_total_ff < RS_W'(RESPONSE_SLOTS)) begin
                  resp_total_in = resp_total_ff + 1'b1;
                  logged_in     = 1'b1;
                  resp_no_in    = 7'(resp_total_ff + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_total_ff   <= '0;
         load_pos_ff     <= '0;
         threat_total_ff <= '0;
         resp_total_ff   <= '0;
         scan_ff         <= 1'b0;
         valid_ff        <= 1'b0;
      end else begin
         rule_total_ff   <= rule_total_in;
         load_pos_ff     <= load_pos_in;
         threat_total_ff <= threat_total_in;
         resp_total_ff   <= resp_total_in;
         scan_ff         <= scan_in;
         valid_ff        <= valid_in;
      end
   end

   // hold result payload and scan context
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      src_ff       <= src_in;
      kind_ff      <= kind_in;
      acc_ff       <= acc_in;
      rule_no_ff   <= rule_no_in;
      threat_no_ff <= threat_no_in;
      class_ff     <= class_in;
      sev_ff       <= sev_in;
      conf_ff      <= conf_in;
      logged_ff    <= logged_in;
      resp_no_ff   <= resp_no_in;
      act_ff       <= act_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_rule_number     = rule_no_ff;
   assign rsp_threat_number   = threat_no_ff;
   assign rsp_threat_class    = class_ff;
   assign rsp_severity_level  = sev_ff;
   assign rsp_confidence_pct  = conf_ff;
   assign rsp_response_logged = logged_ff;
   assign rsp_response_number = resp_no_ff;
   assign rsp_action_taken    = act_ff;

   // at most one cell handles the token in any cycle
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("scan token held by more than one cell");

   // a scan ends with exactly one result beat and frees the block
   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      scan_done |=> (rsp_valid && rsp_result_kind == rptd_pkg::KIND_EVENT && !busy))
      else $error("scan end without event result beat");

   // a logged response always comes with a created threat
   a_resp_needs_threat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_response_logged) |-> rsp_accepted)
      else $error("response logged without threat");

   // the threat count never passes the table size
   a_threat_bound: assert property (@(posedge clock) disable iff (reset)
      threat_total_ff <= TT_W'(THREAT_SLOTS))
      else $error("threat count beyond table");

endmodule
